@@ rtl/core/xylm_pkg.sv @@
`timescale 1ns / 1ps

package xylm_pkg;

  // Q30 Taylor coefficients of the quarter-turn sine
  localparam logic [31:0] C1 = 32'd1686629713;
  localparam logic [31:0] C3 = 32'd693598668;
  localparam logic [31:0] C5 = 32'd85569306;
  localparam logic [31:0] C7 = 32'd5026995;
  localparam logic [31:0] C9 = 32'd172272;

  localparam logic [31:0] LN2_Q30   = 32'd744261118;
  localparam logic [31:0] LOG2E_Q16 = 32'd94548;
  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
  localparam logic [16:0] UNIT      = 17'd32768;

  localparam logic [0:0] REG_BETA = 1'b0;
  localparam logic [0:0] REG_SIDE = 1'b1;

  typedef logic signed [16:0] trig_val_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } trig_stat_t;

endpackage

@@ rtl/core/xylm_ram.sv @@
`timescale 1ns / 1ps

module xylm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/xylm_mul.sv @@
`timescale 1ns / 1ps

module xylm_mul (
  input  logic              clk,
  input  xylm_pkg::mul_req_t req,
  output logic [63:0]       prod
);

  import xylm_pkg::*;

  always_ff @(posedge clk) begin
    prod <= 64'(req.a) * 64'(req.b);
  end

endmodule

@@ rtl/core/xylm_trig.sv @@
`timescale 1ns / 1ps

// cosine of an angle: fold to a quarter turn, then Horner sine over the shared multiplier
module xylm_trig #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [ANGLE_BITS-1:0]   angle,
  input  logic [63:0]             prod,
  output xylm_pkg::mul_req_t      req,
  output xylm_pkg::trig_stat_t    stat,
  output xylm_pkg::trig_val_t     value
);

  import xylm_pkg::*;

  localparam logic [ANGLE_BITS-1:0] HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  typedef enum logic [2:0] {T_IDLE, T_SQ, T_C9, T_C7, T_C5, T_C3, T_C1, T_RND} tstate_t;

  tstate_t state;
  logic [31:0] u;
  logic [31:0] u2;
  logic        neg;
  logic        done;

  logic [ANGLE_BITS-1:0] fold;
  logic [ANGLE_BITS-1:0] z;
  logic                  z_neg;
  logic [31:0]           hsh;
  logic [33:0]           rnd;
  logic [16:0]           mag;

  always_comb begin
    fold = (angle > HALF) ? (ANGLE_BITS'(0) - angle) : angle;
    if (fold <= QUARTER) begin
      z     = QUARTER - fold;
      z_neg = 1'b0;
    end else begin
      z     = fold - QUARTER;
      z_neg = 1'b1;
    end
    hsh = prod[61:30];
    rnd = prod[63:30] + 34'd16384;
    mag = (rnd[33:15] > 19'(UNIT)) ? UNIT : rnd[31:15];
  end

  always_comb begin
    req = '0;
    unique case (state)
      T_IDLE: req = '0;
      T_SQ:   req = '{a: u, b: u};
      T_C9:   req = '{a: {1'b0, prod[60:30]}, b: C9};
      T_C7:   req = '{a: u2, b: C7 - hsh};
      T_C5:   req = '{a: u2, b: C5 - hsh};
      T_C3:   req = '{a: u2, b: C3 - hsh};
      T_C1:   req = '{a: u, b: C1 - hsh};
      T_RND:  req = '0;
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (start) begin
            u     <= 32'(z) << (32 - ANGLE_BITS);
            neg   <= z_neg;
            state <= T_SQ;
          end
        end
        T_SQ: state <= T_C9;
        T_C9: begin
          u2    <= {1'b0, prod[60:30]};
          state <= T_C7;
        end
        T_C7: state <= T_C5;
        T_C5: state <= T_C3;
        T_C3: state <= T_C1;
        T_C1: state <= T_RND;
        T_RND: begin
          value <= neg ? (17'sd0 - $signed(mag)) : $signed(mag);
          done  <= 1'b1;
          state <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  assign stat = '{busy: (state != T_IDLE), done: done};

endmodule

@@ rtl/core/xy_lattice_metropolis_update.sv @@
`timescale 1ns / 1ps

// Metropolis trial engine for a periodic cubic lattice of planar spins.
// s_axis carries one trial per beat: site x/y/z, angle offset and a uniform
// draw. m_axis returns one beat per trial: the accept flag in tuser and the
// running energy, x/y magnetization and x-direction sine sum in tdata.
// cfg_we/cfg_index/cfg_data write beta (index 0) and the side length
// (index 1); a change of side restarts the ordered half-turn lattice.
// s_axis_tready comes back in the same cycle as the result beat. A trial
// makes 7 reads of the angle memory; all trig, the energy exponent and its
// table entry go through one 32x32 multiplier, 12 cosines for the energy
// change and 8 more on acceptance. One trial is in flight at a time.
// Reset, and any change of side, run a clearing pass over all
// 2^(3*ceil(log2(MAX_SIDE))) entries of the angle memory (4096 by default)
// before the first trial is taken. A stalled m_axis holds its beat; the next
// trial is taken meanwhile and its result waits until the held beat has gone.
module xy_lattice_metropolis_update #(
  parameter int MAX_SIDE       = 16,
  parameter int ANGLE_BITS     = 16,
  parameter int EXP_TABLE_BITS = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // site_x, site_y, site_z, angle_step, accept_draw, pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,   // energy_sum, x_magnetization, y_magnetization,
                                       // x_sine_sum, pad
  output logic [0:0]   m_axis_tuser,   // accepted
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  import xylm_pkg::*;

  localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int AB    = ANGLE_BITS;
  localparam int ETB   = EXP_TABLE_BITS;
  localparam int SHL   = (AB >= 16) ? AB - 16 : 0;
  localparam int SHR   = (AB < 16) ? 16 - AB : 0;
  localparam logic [AB-1:0] HALF    = AB'(1) << (AB - 1);
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
  localparam logic [4:0] SIDE_MAX   = (MAX_SIDE > 31) ? 5'd31 : 5'(MAX_SIDE);
  localparam logic [4:0] SIDE_RESET = (SIDE_MAX < 5'd16) ? SIDE_MAX : 5'd16;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RD, S_DE_GO, S_DE_WAIT, S_P1, S_P2, S_P3, S_P4,
    S_EW, S_EM, S_ED, S_EC, S_EF, S_DEC, S_A_GO, S_A_WAIT, S_PUT
  } state_t;

  function automatic logic [29:0] start_energy(input logic [4:0] l);
    logic [14:0] s;
    s = 15'(l) * 15'(l) * 15'(l);
    return 30'(0) - 30'({17'(17'(s) * 17'd3), 15'd0});
  endfunction

  function automatic logic [28:0] start_xmag(input logic [4:0] l);
    logic [14:0] s;
    s = 15'(l) * 15'(l) * 15'(l);
    return 29'(0) - 29'({s, 15'd0});
  endfunction

  function automatic logic [31:0] recip(input logic [3:0] n);
    logic [31:0] r;
    case (n)
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  state_t state;
  logic [15:0] beta;
  logic [4:0]  lsize;
  logic [AW-1:0] clr_addr;

  logic [3:0]  lx, ly, lz;
  logic [AB-1:0] step;
  logic [15:0] draw;
  logic [2:0]  rc;
  logic [3:0]  job;
  logic [AB-1:0] rd_vals [7];

  logic signed [19:0] de;
  logic signed [29:0] energy;
  logic signed [28:0] xmag, ymag, sxsum;
  logic        acc_flag;

  logic [15:0] p_lo;
  logic [35:0] hi;
  logic [4:0]  k;
  logic [29:0] w;
  logic [30:0] et;
  logic [30:0] ea;
  logic [3:0]  n;
  logic [16:0] prob;

  logic        out_acc;
  logic [29:0] out_e;
  logic [28:0] out_xm, out_ym, out_sx;

  // datapath signals
  logic [4:0]  x5, y5, z5;
  logic [4:0]  xm5, xp5, ym5, yp5, zm5, zp5;
  logic [AW-1:0] raddr, waddr, center;
  logic [AB-1:0] wdata;
  logic        ram_we;
  logic [AB-1:0] ram_rdata;
  logic [AB-1:0] old_a, neu_a, nb_sel;
  logic [AB-1:0] t_angle;
  logic        trig_start;
  logic [63:0] mul_prod;
  mul_req_t    trig_req, exp_req, mul_req;
  trig_stat_t  trig_stat;
  trig_val_t   trig_value;
  logic        exp_phase;
  logic [52:0] y;
  logic [31:0] q0;
  logic [34:0] q0n;
  logic [34:0] rem;
  logic [30:0] q;
  logic [16:0] entry;
  logic [4:0]  l_new;
  logic        side_chg;
  logic        put_go;
  logic        in_ok;
  logic [3:0]  in_x, in_y, in_z;
  logic [23:0] step_wide;

  assign in_x = s_axis_tdata[3:0];
  assign in_y = s_axis_tdata[7:4];
  assign in_z = s_axis_tdata[11:8];
  assign step_wide = ({8'd0, s_axis_tdata[27:12]} << SHL) >> SHR;
  assign in_ok = ({1'b0, in_x} < lsize) && ({1'b0, in_y} < lsize) && ({1'b0, in_z} < lsize);

  always_comb begin
    x5  = {1'b0, lx};
    y5  = {1'b0, ly};
    z5  = {1'b0, lz};
    xm5 = (x5 == 5'd0) ? lsize - 5'd1 : x5 - 5'd1;
    xp5 = (x5 + 5'd1 == lsize) ? 5'd0 : x5 + 5'd1;
    ym5 = (y5 == 5'd0) ? lsize - 5'd1 : y5 - 5'd1;
    yp5 = (y5 + 5'd1 == lsize) ? 5'd0 : y5 + 5'd1;
    zm5 = (z5 == 5'd0) ? lsize - 5'd1 : z5 - 5'd1;
    zp5 = (z5 + 5'd1 == lsize) ? 5'd0 : z5 + 5'd1;
    center = {CW'(x5), CW'(y5), CW'(z5)};
    case (rc)
      3'd1:    raddr = {CW'(xm5), CW'(y5), CW'(z5)};
      3'd2:    raddr = {CW'(xp5), CW'(y5), CW'(z5)};
      3'd3:    raddr = {CW'(x5), CW'(ym5), CW'(z5)};
      3'd4:    raddr = {CW'(x5), CW'(yp5), CW'(z5)};
      3'd5:    raddr = {CW'(x5), CW'(y5), CW'(zm5)};
      3'd6:    raddr = {CW'(x5), CW'(y5), CW'(zp5)};
      default: raddr = center;
    endcase
  end

  always_comb begin
    old_a  = rd_vals[0];
    neu_a  = rd_vals[0] + step;
    nb_sel = rd_vals[3'(job[3:1]) + 3'd1];
    if (state == S_A_GO) begin
      case (job[2:0])
        3'd0:    t_angle = neu_a;
        3'd1:    t_angle = old_a;
        3'd2:    t_angle = neu_a - QUARTER;
        3'd3:    t_angle = old_a - QUARTER;
        3'd4:    t_angle = rd_vals[1] - neu_a - QUARTER;
        3'd5:    t_angle = neu_a - rd_vals[2] - QUARTER;
        3'd6:    t_angle = rd_vals[1] - old_a - QUARTER;
        default: t_angle = old_a - rd_vals[2] - QUARTER;
      endcase
    end else begin
      t_angle = (job[0] ? neu_a : old_a) - nb_sel;
    end
    trig_start = (state == S_DE_GO) || (state == S_A_GO);
  end

  assign ram_we = (state == S_CLR) || ((state == S_DEC) && ({1'b0, draw} < prob));
  assign waddr  = (state == S_CLR) ? clr_addr : center;
  assign wdata  = (state == S_CLR) ? HALF : neu_a;

  // exponent and table-entry arithmetic on the shared multiplier
  always_comb begin
    y     = 53'({hi, 16'd0}) + 53'(mul_prod[32:0]);
    q0    = mul_prod[63:32];
    q0n   = 35'(q0) * 35'(n);
    rem   = 35'(ea) - q0n;
    if (n == 4'd1) begin
      q = ea;
    end else begin
      q = (rem >= 35'(n)) ? 31'(q0) + 31'd1 : 31'(q0);
    end
    entry = 17'((32'(et) + 32'd8192) >> 14);
    exp_req   = '0;
    exp_phase = 1'b1;
    unique case (state)
      S_P1: exp_req = '{a: 32'(beta), b: 32'(de[18:0])};
      S_P2: exp_req = '{a: 32'(mul_prod[34:16]), b: LOG2E_Q16};
      S_P3: exp_req = '{a: 32'(p_lo), b: LOG2E_Q16};
      S_P4: exp_req = '{a: 32'(y[42:43-ETB]), b: LN2_Q30};
      S_EM: exp_req = '{a: 32'(w), b: 32'(et)};
      S_ED: exp_req = '{a: 32'(mul_prod[60:30]), b: recip(n)};
      default: exp_phase = 1'b0;
    endcase
    mul_req = exp_phase ? exp_req : trig_req;
  end

  always_comb begin
    l_new = cfg_data[4:0];
    if (l_new < 5'd2) begin
      l_new = 5'd2;
    end
    if (l_new > SIDE_MAX) begin
      l_new = SIDE_MAX;
    end
  end

  assign side_chg = cfg_we && (cfg_index == REG_SIDE) && (l_new != lsize);
  assign put_go   = (state == S_PUT) && (!m_axis_tvalid || m_axis_tready) && !side_chg;

  assign s_axis_tready = (state == S_IDLE);

  xylm_ram #(.WIDTH(AB), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(ram_rdata)
  );

  xylm_mul u_mul (.clk(clk), .req(mul_req), .prod(mul_prod));

  xylm_trig #(.ANGLE_BITS(AB)) u_trig (
    .clk(clk), .rst(rst), .start(trig_start), .angle(t_angle), .prod(mul_prod),
    .req(trig_req), .stat(trig_stat), .value(trig_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_addr      <= '0;
      beta          <= 16'd1860;
      lsize         <= SIDE_RESET;
      energy        <= start_energy(SIDE_RESET);
      xmag          <= start_xmag(SIDE_RESET);
      ymag          <= '0;
      sxsum         <= '0;
      m_axis_tvalid <= 1'b0;
      acc_flag      <= 1'b0;
      rc            <= '0;
      job           <= '0;
    end else begin
      if (put_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we && (cfg_index == REG_BETA)) begin
        beta <= cfg_data;
      end
      if (side_chg) begin
        lsize    <= l_new;
        energy   <= start_energy(l_new);
        xmag     <= start_xmag(l_new);
        ymag     <= '0;
        sxsum    <= '0;
        clr_addr <= '0;
        state    <= S_CLR;
      end else begin
        unique case (state)
          S_CLR: begin
            clr_addr <= clr_addr + AW'(1);
            if (clr_addr == '1) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (s_axis_tvalid) begin
              lx       <= in_x;
              ly       <= in_y;
              lz       <= in_z;
              step     <= AB'(step_wide);
              draw     <= s_axis_tdata[43:28];
              acc_flag <= 1'b0;
              rc       <= '0;
              state    <= in_ok ? S_RD : S_PUT;
            end
          end
          S_RD: begin
            if (rc != 3'd0) begin
              rd_vals[rc - 3'd1] <= ram_rdata;
            end
            rc <= rc + 3'd1;
            if (rc == 3'd7) begin
              job   <= '0;
              de    <= '0;
              state <= S_DE_GO;
            end
          end
          S_DE_GO: state <= S_DE_WAIT;
          S_DE_WAIT: begin
            if (trig_stat.done) begin
              de <= job[0] ? de - 20'(trig_value) : de + 20'(trig_value);
              if (job == 4'd11) begin
                state <= S_P1;
              end else begin
                job   <= job + 4'd1;
                state <= S_DE_GO;
              end
            end
          end
          S_P1: begin
            if (de[19] || (de == 20'sd0)) begin
              prob  <= 17'h10000;
              state <= S_DEC;
            end else begin
              state <= S_P2;
            end
          end
          S_P2: begin
            p_lo  <= mul_prod[15:0];
            state <= S_P3;
          end
          S_P3: begin
            hi    <= mul_prod[35:0];
            state <= S_P4;
          end
          S_P4: begin
            if (y[52:43] >= 10'd17) begin
              prob  <= '0;
              state <= S_DEC;
            end else begin
              k     <= y[47:43];
              state <= S_EW;
            end
          end
          S_EW: begin
            w     <= mul_prod[ETB+29:ETB];
            et    <= Q30_ONE;
            n     <= 4'd8;
            state <= S_EM;
          end
          S_EM: state <= S_ED;
          S_ED: begin
            ea    <= mul_prod[60:30];
            state <= S_EC;
          end
          S_EC: begin
            et <= Q30_ONE - q;
            if (n == 4'd1) begin
              state <= S_EF;
            end else begin
              n     <= n - 4'd1;
              state <= S_EM;
            end
          end
          S_EF: begin
            prob  <= entry >> k;
            state <= S_DEC;
          end
          S_DEC: begin
            if ({1'b0, draw} < prob) begin
              acc_flag <= 1'b1;
              energy   <= energy + 30'(de);
              job      <= '0;
              state    <= S_A_GO;
            end else begin
              state <= S_PUT;
            end
          end
          S_A_GO: state <= S_A_WAIT;
          S_A_WAIT: begin
            if (trig_stat.done) begin
              case (job[2:0])
                3'd0:    xmag  <= xmag + 29'(trig_value);
                3'd1:    xmag  <= xmag - 29'(trig_value);
                3'd2:    ymag  <= ymag + 29'(trig_value);
                3'd3:    ymag  <= ymag - 29'(trig_value);
                3'd4,
                3'd5:    sxsum <= sxsum + 29'(trig_value);
                default: sxsum <= sxsum - 29'(trig_value);
              endcase
              if (job == 4'd7) begin
                state <= S_PUT;
              end else begin
                job   <= job + 4'd1;
                state <= S_A_GO;
              end
            end
          end
          S_PUT: begin
            if (put_go) begin
              out_acc <= acc_flag;
              out_e   <= energy;
              out_xm  <= xmag;
              out_ym  <= ymag;
              out_sx  <= sxsum;
              state   <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  assign m_axis_tdata = {3'd0, out_sx, out_ym, out_xm, out_e};
  assign m_axis_tuser = out_acc;

`ifndef NO_ASSERTIONS
  a_trig_owned: assert property (@(posedge clk) disable iff (rst)
    trig_stat.busy |-> (state == S_DE_WAIT || state == S_A_WAIT))
    else $error("trig unit running outside a trig wait state");

  a_one_trial: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second trial taken while one is in flight");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    trig_stat.done |-> (state == S_DE_WAIT || state == S_A_WAIT))
    else $error("trig result with nobody waiting");
`endif

endmodule
